[rtl/dss_pkg.sv]
// dss_pkg: shared constants, codes and control types for the delimiter splitter
// no dependencies; used by every file of the block

package dss_pkg;

  localparam int MAX_DELIM = 8;
  localparam int CNT_W     = 4;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int CFG_IDX_W = 1;
  localparam int KIND_W    = 2;
  localparam int OP_W      = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 1'd1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TOKEN_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_TOKEN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_STRING = 2'd2;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH       = 3'd1;
  localparam logic [OP_W-1:0] OP_EMIT       = 3'd2;
  localparam logic [OP_W-1:0] OP_END_TOKEN  = 3'd3;
  localparam logic [OP_W-1:0] OP_END_STRING = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            use_held;
    logic            capture;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic             drain;
    logic             empty;
    logic             started;
    logic             fin_held;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage

[rtl/dss_stream_if.sv]
// dss_stream_if: valid/ready channels for input bytes and result words
// depends on dss_pkg

interface dss_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       final_char;

  modport source (output valid, output char_byte, output final_char, input ready);
  modport sink (input valid, input char_byte, input final_char, output ready);
endinterface

interface dss_result_if;
  logic                      valid;
  logic                      ready;
  logic [dss_pkg::KIND_W-1:0] kind;
  logic [7:0]                out_byte;
  logic                      last_result;

  modport source (output valid, output kind, output out_byte, output last_result, input ready);
  modport sink (input valid, input kind, input out_byte, input last_result, output ready);
endinterface

[rtl/dss_datapath.sv]
// dss_datapath: pending-byte window, delimiter compare, config registers, result register
// depends on dss_pkg; driven by dss_ctrl commands

module dss_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dss_pkg::DATA_W-1:0]     cfg_wdata,
  input  logic [7:0]                     in_byte,
  input  logic                           in_fin,
  input  dss_pkg::cmd_t                  cmd,
  output dss_pkg::status_t               status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dss_pkg::KIND_W-1:0]     out_kind,
  output logic [7:0]                     out_byte,
  output logic                           out_last
);

  logic [dss_pkg::LEN_W-1:0]  delim_len;
  logic [dss_pkg::DATA_W-1:0] delim_bytes;
  logic [dss_pkg::LEN_W-1:0]  len;
  logic [dss_pkg::CNT_W-1:0]  count;
  logic [dss_pkg::CNT_W-1:0]  count_next;
  logic                       started;
  logic                       started_next;
  logic [7:0]                 held_byte;
  logic                       held_fin;
  logic [7:0]                 win [dss_pkg::MAX_DELIM];
  logic [7:0]                 win_next [dss_pkg::MAX_DELIM];
  logic [7:0]                 cand [dss_pkg::MAX_DELIM];
  logic [7:0]                 cur_byte;
  logic                       full;
  logic                       match;
  logic                       load;
  logic [dss_pkg::KIND_W-1:0] kind_next;
  logic [7:0]                 byte_next;

  // effective length: zero reads as one, clamp at window size
  always_comb begin
    if (delim_len == '0) begin
      len = dss_pkg::LEN_W'(1);
    end else if (delim_len > dss_pkg::LEN_W'(dss_pkg::MAX_DELIM)) begin
      len = dss_pkg::LEN_W'(dss_pkg::MAX_DELIM);
    end else begin
      len = delim_len;
    end
  end

  assign cur_byte = cmd.use_held ? held_byte : in_byte;
  assign full     = (count + dss_pkg::CNT_W'(1)) == dss_pkg::CNT_W'(len);

  // window with the new byte in place, compared against the delimiter
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < dss_pkg::MAX_DELIM; i++) begin
      cand[i] = (dss_pkg::CNT_W'(i) == count) ? cur_byte : win[i];
      if ((dss_pkg::LEN_W'(i) < len) && (cand[i] != delim_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    count_next   = count;
    started_next = started;
    load         = 1'b0;
    kind_next    = dss_pkg::KIND_TOKEN_BYTE;
    byte_next    = 8'd0;
    for (int i = 0; i < dss_pkg::MAX_DELIM; i++) begin
      win_next[i] = win[i];
    end
    case (cmd.op)
      dss_pkg::OP_PUSH: begin
        if (full && match) begin
          count_next   = '0;
          started_next = 1'b0;
          load         = started;
          kind_next    = dss_pkg::KIND_END_TOKEN;
        end else if (full) begin
          // oldest byte leaves, count stays at len - 1
          started_next = 1'b1;
          load         = 1'b1;
          byte_next    = cand[0];
          for (int i = 0; i < dss_pkg::MAX_DELIM - 1; i++) begin
            win_next[i] = cand[i+1];
          end
        end else begin
          count_next = count + dss_pkg::CNT_W'(1);
          for (int i = 0; i < dss_pkg::MAX_DELIM; i++) begin
            win_next[i] = cand[i];
          end
        end
      end
      dss_pkg::OP_EMIT: begin
        count_next   = count - dss_pkg::CNT_W'(1);
        started_next = 1'b1;
        load         = 1'b1;
        byte_next    = win[0];
        for (int i = 0; i < dss_pkg::MAX_DELIM - 1; i++) begin
          win_next[i] = win[i+1];
        end
      end
      dss_pkg::OP_END_TOKEN: begin
        started_next = 1'b0;
        load         = 1'b1;
        kind_next    = dss_pkg::KIND_END_TOKEN;
      end
      dss_pkg::OP_END_STRING: begin
        load      = 1'b1;
        kind_next = dss_pkg::KIND_END_STRING;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_len   <= dss_pkg::LEN_W'(1);
      delim_bytes <= dss_pkg::DATA_W'(44);
      count       <= '0;
      started     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == dss_pkg::REG_DELIM_LEN) begin
        delim_len <= cfg_wdata[dss_pkg::LEN_W-1:0];
      end
      if (cfg_we && cfg_index == dss_pkg::REG_DELIM_BYTES) begin
        delim_bytes <= cfg_wdata;
      end
      count     <= count_next;
      started   <= started_next;
      out_valid <= load | (out_valid & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < dss_pkg::MAX_DELIM; i++) begin
      win[i] <= win_next[i];
    end
    if (cmd.capture) begin
      held_byte <= in_byte;
      held_fin  <= in_fin;
    end
    if (load) begin
      out_kind <= kind_next;
      out_byte <= byte_next;
      out_last <= cmd.last;
    end
  end

  assign status.drain    = count >= dss_pkg::CNT_W'(len);
  assign status.empty    = count == '0;
  assign status.started  = started;
  assign status.fin_held = held_fin;
  assign status.out_free = ~out_valid | out_ready;
  assign status.count    = count;

endmodule

[rtl/dss_ctrl.sv]
// dss_ctrl: sequencer for accept, window drain and end-of-string flush
// depends on dss_pkg; commands dss_datapath

module dss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_fin,
  output logic             in_ready,
  input  dss_pkg::status_t status,
  output dss_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.op       = dss_pkg::OP_NONE;
    cmd.use_held = 1'b0;
    cmd.capture  = 1'b0;
    cmd.last     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd.capture = 1'b1;
          if (status.drain) begin
            state_next = S_DRAIN;
          end else begin
            cmd.op     = dss_pkg::OP_PUSH;
            cmd.last   = ~in_fin;
            state_next = in_fin ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        if (status.out_free) begin
          if (status.drain) begin
            cmd.op = dss_pkg::OP_EMIT;
          end else begin
            cmd.op       = dss_pkg::OP_PUSH;
            cmd.use_held = 1'b1;
            cmd.last     = ~status.fin_held;
            state_next   = status.fin_held ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          if (!status.empty) begin
            cmd.op = dss_pkg::OP_EMIT;
          end else if (status.started) begin
            cmd.op = dss_pkg::OP_END_TOKEN;
          end else begin
            cmd.op     = dss_pkg::OP_END_STRING;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/delimiter_string_splitter.sv]
// delimiter_string_splitter: top level, splits a byte string into tokens on a delimiter
// depends on dss_pkg, dss_stream_if, dss_ctrl, dss_datapath
//
//   port       direction  handshake          word
//   char_in    in         valid / ready      char_byte, final_char
//   res_out    out        valid / ready      kind, out_byte, last_result
//   cfg        in         cfg_we only        cfg_index, cfg_wdata
//
// an ordinary byte's result, if any, is loaded into the output register in the
// same cycle that the byte is taken
// after a final byte, each pending window byte is emitted, then an end-of-token
// word when a token is open, then the end-of-string word
// after the delimiter length is shortened, the next byte is captured and held
// while the window bytes that must leave first are emitted, then it is pushed
// reset is synchronous; no clearing pass, the window is only read below its count
// a stalled output register holds the sequencer and blocks new bytes

module delimiter_string_splitter (
  input  logic                          clk,
  input  logic                          rst,
  dss_char_if.sink                      char_in,
  dss_result_if.source                  res_out,
  input  logic                          cfg_we,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dss_pkg::DATA_W-1:0]    cfg_wdata
);

  dss_pkg::cmd_t    cmd;
  dss_pkg::status_t status;

  // sequencer: accept, drain on a shortened length, flush on the final byte
  dss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_fin   (char_in.final_char),
    .in_ready (char_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // window, compare, config registers and the output register
  dss_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_byte   (char_in.char_byte),
    .in_fin    (char_in.final_char),
    .cmd       (cmd),
    .status    (status),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_kind  (res_out.kind),
    .out_byte  (res_out.out_byte),
    .out_last  (res_out.last_result)
  );

`ifndef ASSERT_OFF
  // the window never holds more than the delimiter maximum
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    status.count <= dss_pkg::CNT_W'(dss_pkg::MAX_DELIM))
    else $error("window count out of range");

  // end of string leaves an empty window and no open token
  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.kind == dss_pkg::KIND_END_STRING) |->
      (status.empty && !status.started))
    else $error("state not clean at end of string");

  // end of string always closes the item's results
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.kind == dss_pkg::KIND_END_STRING) |-> res_out.last_result)
    else $error("end of string not marked last");

  // a byte is never taken while a result word is stuck in the output register
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready) |-> (!res_out.valid || res_out.ready))
    else $error("byte accepted over a stalled result");
`endif

endmodule
